// ===== sv/tcw_pkg.sv =====
// Package for the text console writer: screen geometry, cell constants,
// field widths for the interfaces and the enum types used by the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  localparam int unsigned COLUMNS     = 80;
  localparam int unsigned ROWS        = 25;
  localparam int unsigned TOTAL_CELLS = COLUMNS * ROWS;
  localparam int unsigned LAST_ROW    = (ROWS - 1) * COLUMNS;

  localparam int unsigned CELL_AW = $clog2(TOTAL_CELLS);
  localparam int unsigned CNT_W   = $clog2(TOTAL_CELLS + 1);
  localparam int unsigned COL_W   = $clog2(COLUMNS);

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned INDEX_W  = 11;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CELL_W   = 16;
  localparam int unsigned CURSOR_W = 11;

  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0] RETURN_CHAR  = 8'h0D;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0F20;
  localparam logic [7:0]        RESET_ATTR   = 8'h0F;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ECHO  = 2'd0,
    KIND_CELL  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_READ_WAIT,
    ST_SCROLL,
    ST_FILL,
    ST_RESP
  } state_e;

endpackage

`default_nettype wire

// ===== sv/tcw_if.sv =====
// Valid/ready channel interfaces for the text console writer: the request
// channel and the result channel. Depends on tcw_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tcw_in_if
  import tcw_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [CHAR_W-1:0]  char_code;
  logic [INDEX_W-1:0] cell_index;

  modport source (output valid, mode, char_code, cell_index, input ready);
  modport sink   (input valid, mode, char_code, cell_index, output ready);
endinterface

interface tcw_out_if
  import tcw_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [CHAR_W-1:0]   serial_byte;
  logic [CELL_W-1:0]   cell_value;
  logic [CURSOR_W-1:0] cursor;
  logic                last;

  modport source (output valid, kind, serial_byte, cell_value, cursor, last,
                  input ready);
  modport sink   (input valid, kind, serial_byte, cell_value, cursor, last,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/text_console_writer_unit.sv =====
// Text console writer: a sequencer around one cell memory and one address
// counter. Depends on tcw_pkg and the channel interfaces in tcw_if.sv.
//
// Usage: requests arrive on in_i (mode, char_code, cell_index), results leave
// on out_o (kind, serial_byte, cell_value, cursor, last). One request is in
// work at a time; in_i.ready is high only while the block is idle, and every
// transaction on in_i is answered by one result, or two for a newline, the
// final one flagged by last. An unused mode gives no result.
// From acceptance, a put or newline and a read beyond the screen pass the
// dispatch state and then give the result; a read of a cell passes dispatch
// and a read-wait state first. A put or newline that passes the end of the
// screen scrolls through the memory: it copies every row from the second on
// up by one row, then fills the last row with blanks. A clear fills all
// TOTAL_CELLS cells (2000) with blanks. All sweeps are paced by the single
// memory write port, one cell a cycle.
// At reset the attribute is 15, the cursor is homed and a clearing pass
// writes the blank cell to all TOTAL_CELLS entries while in_i.ready stays
// low; attribute writes are taken throughout.
// When out_o.ready is low the result holds and no request is accepted.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_unit
  import tcw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  tcw_in_if.sink          in_i,
  tcw_out_if.source       out_o
);

  logic [CELL_W-1:0] mem [TOTAL_CELLS];

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [COL_W-1:0]     col_q, col_d;
  logic [CELL_AW-1:0]   row_base_q, row_base_d;
  logic [CELL_W-1:0]    blank_q, blank_d;
  logic                 init_q, init_d;
  logic                 second_q, second_d;
  logic                 wr_pend_q, wr_pend_d;
  logic [CELL_AW-1:0]   wr_addr_q, wr_addr_d;
  logic [7:0]           attr_q;
  logic [MODE_W-1:0]    mode_q;
  logic [CHAR_W-1:0]    char_q;
  logic [INDEX_W-1:0]   idx_q;
  logic [CELL_W-1:0]    rdata_q;

  logic                 mem_we;
  logic [CELL_AW-1:0]   mem_wa;
  logic [CELL_W-1:0]    mem_wd;
  logic                 mem_re;
  logic [CELL_AW-1:0]   mem_ra;

  logic [CELL_AW-1:0]   cursor_w;
  logic [CNT_W-1:0]     scroll_dst;
  logic                 in_acc;
  logic                 idx_ok;
  logic                 is_nl;
  logic                 res_last;

  assign cursor_w   = row_base_q + CELL_AW'(col_q);
  assign scroll_dst = cnt_q - CNT_W'(COLUMNS);
  assign in_acc     = in_i.valid && in_i.ready;
  assign idx_ok     = 32'(idx_q) < TOTAL_CELLS;
  assign is_nl      = (char_q == NEWLINE_CHAR);
  assign res_last   = !((mode_q == MODE_PUT) && is_nl && !second_q);

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = (state_q == ST_RESP);
  assign out_o.cursor       = CURSOR_W'(cursor_w);
  assign out_o.last         = res_last;
  assign out_o.kind         = (mode_q == MODE_PUT)   ? KIND_ECHO  :
                              (mode_q == MODE_CLEAR) ? KIND_CLEAR : KIND_CELL;
  assign out_o.serial_byte  = (mode_q != MODE_PUT) ? '0 :
                              !is_nl ? char_q :
                              second_q ? NEWLINE_CHAR : RETURN_CHAR;
  assign out_o.cell_value   = ((mode_q == MODE_READ) && idx_ok) ? rdata_q : '0;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    col_d      = col_q;
    row_base_d = row_base_q;
    blank_d    = blank_q;
    init_d     = init_q;
    second_d   = second_q;
    wr_pend_d  = wr_pend_q;
    wr_addr_d  = wr_addr_q;
    mem_we     = 1'b0;
    mem_wa     = cursor_w;
    mem_wd     = {attr_q, char_q};
    mem_re     = 1'b0;
    mem_ra     = CELL_AW'(idx_q);
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        blank_d = {attr_q, BLANK_CHAR};
        case (mode_q)
          MODE_PUT: begin
            state_d = ST_RESP;
            if (!is_nl) begin
              mem_we = 1'b1;
            end
            if (is_nl || (col_q == COL_W'(COLUMNS - 1))) begin
              col_d = '0;
              if (row_base_q == CELL_AW'(LAST_ROW)) begin
                state_d   = ST_SCROLL;
                cnt_d     = CNT_W'(COLUMNS);
                wr_pend_d = 1'b0;
              end else begin
                row_base_d = row_base_q + CELL_AW'(COLUMNS);
              end
            end else begin
              col_d = col_q + 1'b1;
            end
          end
          MODE_CLEAR: begin
            state_d    = ST_FILL;
            cnt_d      = '0;
            col_d      = '0;
            row_base_d = '0;
          end
          MODE_READ: begin
            if (idx_ok) begin
              mem_re  = 1'b1;
              state_d = ST_READ_WAIT;
            end else begin
              state_d = ST_RESP;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_READ_WAIT: begin
        state_d = ST_RESP;
      end
      ST_SCROLL: begin
        mem_we = wr_pend_q;
        mem_wa = wr_addr_q;
        mem_wd = rdata_q;
        if (cnt_q == CNT_W'(TOTAL_CELLS)) begin
          wr_pend_d = 1'b0;
          cnt_d     = CNT_W'(LAST_ROW);
          state_d   = ST_FILL;
        end else begin
          mem_re    = 1'b1;
          mem_ra    = cnt_q[CELL_AW-1:0];
          wr_pend_d = 1'b1;
          wr_addr_d = scroll_dst[CELL_AW-1:0];
          cnt_d     = cnt_q + 1'b1;
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
        mem_wa = cnt_q[CELL_AW-1:0];
        mem_wd = blank_q;
        if (cnt_q == CNT_W'(TOTAL_CELLS - 1)) begin
          init_d  = 1'b0;
          state_d = init_q ? ST_IDLE : ST_RESP;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_RESP: begin
        if (out_o.ready) begin
          if (res_last) begin
            second_d = 1'b0;
            state_d  = ST_IDLE;
          end else begin
            second_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_FILL;
      cnt_q      <= '0;
      col_q      <= '0;
      row_base_q <= '0;
      blank_q    <= RESET_CELL;
      init_q     <= 1'b1;
      second_q   <= 1'b0;
      wr_pend_q  <= 1'b0;
      attr_q     <= RESET_ATTR;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      col_q      <= col_d;
      row_base_q <= row_base_d;
      blank_q    <= blank_d;
      init_q     <= init_d;
      second_q   <= second_d;
      wr_pend_q  <= wr_pend_d;
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= wr_addr_d;
    if (in_acc) begin
      mode_q <= in_i.mode;
      char_q <= in_i.char_code;
      idx_q  <= in_i.cell_index;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_ra];
    end
  end

`ifndef SYNTHESIS
  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("request accepted while a result is pending");

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(col_q) < COLUMNS) && (32'(row_base_q) <= LAST_ROW))
    else $error("cursor left the screen");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (32'(mem_wa) < TOTAL_CELLS))
    else $error("cell write beyond the screen");

  a_second_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.last) |=> (out_o.valid && out_o.last))
    else $error("newline echo pair broken");

  a_scroll_homes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCROLL) |-> ((col_q == '0) && (row_base_q == CELL_AW'(LAST_ROW))))
    else $error("cursor not at last row start during scroll");
`endif

endmodule

`default_nettype wire

// ===== sim/tcw_result_checker.sv =====
// Result checker for the text console writer: mirrors the screen, cursor and
// attribute, predicts every result transaction and compares it field by field.
// Depends on tcw_pkg and the channel interfaces in tcw_if.sv.
`timescale 1ns / 1ps

module tcw_result_checker
  import tcw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  tcw_in_if           in_mon,
  tcw_out_if          out_mon,
  output int unsigned pending_o,
  output int unsigned error_count_o
);

  typedef struct packed {
    kind_e               kind;
    logic [CHAR_W-1:0]   serial_byte;
    logic [CELL_W-1:0]   cell_value;
    logic [CURSOR_W-1:0] cursor;
    logic                last;
  } console_result_t;

  logic [CELL_W-1:0] screen_q [TOTAL_CELLS];
  int unsigned       cursor_q;
  logic [7:0]        attr_q;
  console_result_t   console_results_q [$];
  int unsigned       error_count;

  function automatic void blank_screen();
    for (int i = 0; i < TOTAL_CELLS; i++) screen_q[i] = {attr_q, BLANK_CHAR};
    cursor_q = 0;
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i < LAST_ROW; i++) screen_q[i] = screen_q[i + COLUMNS];
    for (int i = LAST_ROW; i < TOTAL_CELLS; i++) screen_q[i] = {attr_q, BLANK_CHAR};
    cursor_q = LAST_ROW;
  endfunction

  function automatic void push_result(kind_e kind, logic [CHAR_W-1:0] sbyte,
                                      logic [CELL_W-1:0] cell_v, logic last);
    console_result_t r;
    r.kind        = kind;
    r.serial_byte = sbyte;
    r.cell_value  = cell_v;
    r.cursor      = CURSOR_W'(cursor_q);
    r.last        = last;
    console_results_q.push_back(r);
  endfunction

  function automatic void update_console(logic [MODE_W-1:0] mode,
                                         logic [CHAR_W-1:0] ch,
                                         logic [INDEX_W-1:0] idx);
    logic [CELL_W-1:0] cell_v;
    case (mode)
      MODE_PUT: begin
        if (ch == NEWLINE_CHAR) begin
          cursor_q = (cursor_q / COLUMNS + 1) * COLUMNS;
          if (cursor_q >= TOTAL_CELLS) scroll_screen();
          push_result(KIND_ECHO, RETURN_CHAR, '0, 1'b0);
          push_result(KIND_ECHO, NEWLINE_CHAR, '0, 1'b1);
        end else begin
          screen_q[cursor_q] = {attr_q, ch};
          cursor_q++;
          if (cursor_q >= TOTAL_CELLS) scroll_screen();
          push_result(KIND_ECHO, ch, '0, 1'b1);
        end
      end
      MODE_CLEAR: begin
        blank_screen();
        push_result(KIND_CLEAR, '0, '0, 1'b1);
      end
      MODE_READ: begin
        cell_v = (idx < TOTAL_CELLS) ? screen_q[idx] : '0;
        push_result(KIND_CELL, '0, cell_v, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic void compare_field(string name, logic [CELL_W-1:0] exp_v,
                                        logic [CELL_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      error_count++;
    end
  endfunction

  function automatic void check_result();
    console_result_t exp_r;
    if (console_results_q.size() == 0) begin
      $error("unexpected result transaction: kind %0d, cursor %0d",
             out_mon.kind, out_mon.cursor);
      error_count++;
      return;
    end
    exp_r = console_results_q.pop_front();
    compare_field("kind", CELL_W'(exp_r.kind), CELL_W'(out_mon.kind));
    compare_field("serial_byte", CELL_W'(exp_r.serial_byte), CELL_W'(out_mon.serial_byte));
    compare_field("cell_value", exp_r.cell_value, out_mon.cell_value);
    compare_field("cursor", CELL_W'(exp_r.cursor), CELL_W'(out_mon.cursor));
    compare_field("last", CELL_W'(exp_r.last), CELL_W'(out_mon.last));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q = RESET_ATTR;
      blank_screen();
      console_results_q.delete();
      error_count = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) check_result();
      if (cfg_we_i) attr_q = cfg_wdata_i;
      if (in_mon.valid && in_mon.ready)
        update_console(in_mon.mode, in_mon.char_code, in_mon.cell_index);
    end
    pending_o     <= console_results_q.size();
    error_count_o <= error_count;
  end

endmodule

// ===== sim/text_console_writer_unit_tb.sv =====
// Testbench top for text_console_writer_unit: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict. Depends on tcw_pkg, tcw_if.sv,
// the block itself and tcw_result_checker.
`timescale 1ns / 1ps

module text_console_writer_unit_tb;
  import tcw_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED    = 2'd3;
  localparam int unsigned       RANDOM_ITEMS   = 750;
  localparam int unsigned       WATCHDOG_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  int unsigned pending_results;
  int unsigned check_errors;
  int unsigned burst_left;
  int unsigned idle_cycles;
  int unsigned ready_seg_left;
  int unsigned ready_seg_kind;
  int unsigned random_sent;
  int unsigned phase_idx;

  tcw_in_if  in_ch ();
  tcw_out_if out_ch ();

  text_console_writer_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  tcw_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .pending_o     (pending_results),
    .error_count_o (check_errors)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: segments of steady ready, random ready and full stall.
  always @(posedge clk_i) begin
    if (ready_seg_left == 0) begin
      ready_seg_kind <= $urandom_range(2, 0);
      ready_seg_left <= $urandom_range(40, 4);
    end else begin
      ready_seg_left <= ready_seg_left - 1;
    end
    case (ready_seg_kind)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(1, 0));
      default: out_ch.ready <= 1'b0;
    endcase
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_request(logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] ch,
                              logic [INDEX_W-1:0] idx);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= mode;
    in_ch.char_code  <= ch;
    in_ch.cell_index <= idx;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Hold off until every result is in and the block is idle again.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_results != 0 || !in_ch.ready);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_attribute(logic [7:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int unsigned n_items, int unsigned put_pct,
                              int unsigned nl_pct);
    int unsigned       sent;
    int unsigned       roll;
    logic [MODE_W-1:0]  mode;
    logic [CHAR_W-1:0]  ch;
    logic [INDEX_W-1:0] idx;
    sent = 0;
    while (sent < n_items) begin
      ch   = CHAR_W'($urandom_range(255, 0));
      roll = $urandom_range(99, 0);
      if (roll < 10)      idx = INDEX_W'($urandom_range(2047, TOTAL_CELLS));
      else if (roll < 55) idx = INDEX_W'($urandom_range(TOTAL_CELLS - 1, LAST_ROW - COLUMNS));
      else if (roll < 70) idx = INDEX_W'($urandom_range(3 * COLUMNS - 1, 0));
      else                idx = INDEX_W'($urandom_range(TOTAL_CELLS - 1, 0));
      roll = $urandom_range(99, 0);
      if (roll < put_pct) begin
        mode = MODE_PUT;
        if ($urandom_range(99, 0) < nl_pct) ch = NEWLINE_CHAR;
      end else if (roll < put_pct + 2) begin
        mode = MODE_CLEAR;
      end else if (roll < 96) begin
        mode = MODE_READ;
      end else begin
        mode = MODE_UNUSED;
      end
      send_request(mode, ch, idx);
      if (mode != MODE_UNUSED) sent++;
    end
  endtask

  initial begin
    int unsigned n_items;
    int unsigned nl_pct;
    logic [7:0]  attr;
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.mode       = MODE_PUT;
    in_ch.char_code  = '0;
    in_ch.cell_index = '0;
    out_ch.ready     = 1'b0;
    ready_seg_left   = 0;
    ready_seg_kind   = 0;
    burst_left       = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);

    send_request(MODE_READ, 8'h00, 11'd0);
    send_request(MODE_READ, 8'h00, 11'd1999);
    send_request(MODE_READ, 8'h00, 11'd2000);
    send_request(MODE_READ, 8'h00, 11'd2047);
    send_request(MODE_PUT, 8'h41, 11'd0);
    send_request(MODE_PUT, 8'hFF, 11'd0);
    send_request(MODE_PUT, 8'h00, 11'd0);
    send_request(MODE_PUT, NEWLINE_CHAR, 11'd0);
    send_request(MODE_PUT, RETURN_CHAR, 11'd0);
    send_request(MODE_UNUSED, 8'h41, 11'd5);
    send_request(MODE_READ, 8'h00, 11'd0);
    send_request(MODE_READ, 8'h00, 11'd2);
    send_request(MODE_READ, 8'h00, 11'd80);
    write_attribute(8'h00);
    send_request(MODE_PUT, 8'h7E, 11'd0);
    send_request(MODE_READ, 8'h00, 11'd81);
    send_request(MODE_CLEAR, 8'h00, 11'd0);
    send_request(MODE_READ, 8'h00, 11'd81);
    write_attribute(8'hFF);
    send_request(MODE_PUT, 8'h55, 11'd0);
    send_request(MODE_READ, 8'h00, 11'd0);
    send_request(MODE_PUT, NEWLINE_CHAR, 11'd0);
    send_request(MODE_CLEAR, 8'h00, 11'd0);
    send_request(MODE_READ, 8'h00, 11'd1999);

    random_sent = 0;
    phase_idx   = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case (phase_idx)
        0:       attr = 8'h00;
        1:       attr = 8'hFF;
        2:       attr = RESET_ATTR;
        default: attr = 8'($urandom_range(255, 0));
      endcase
      write_attribute(attr);
      n_items = $urandom_range(120, 50);
      if (n_items > RANDOM_ITEMS - random_sent) n_items = RANDOM_ITEMS - random_sent;
      case ($urandom_range(2, 0))
        0:       nl_pct = 0;
        1:       nl_pct = 4;
        default: nl_pct = 30;
      endcase
      random_phase(n_items, $urandom_range(90, 55), nl_pct);
      random_sent += n_items;
      phase_idx++;
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (check_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tcw_pkg.sv
sv/tcw_if.sv
sv/text_console_writer_unit.sv
sim/tcw_result_checker.sv
sim/text_console_writer_unit_tb.sv
